/* hdl/csfp_pkg.sv */
package csfp_pkg;

    localparam int PAYLOAD_WORDS_DEF = 8;

    localparam int BYTE_W     = 8;
    localparam int ID_W       = 32;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 3;
    localparam int WORD_W     = 64;
    localparam int KIND_W     = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_OK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HDR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    // header bytes
    localparam logic [7:0] HDR_SUM    = 8'h44;
    localparam logic [7:0] HDR_CRC    = 8'h66;
    localparam logic [7:0] HDR_SYNC1  = 8'h33;
    localparam logic [7:0] HDR_SYNC2  = 8'h22;
    localparam logic [7:0] LEN_MIN    = 8'h11;
    localparam logic [7:0] LEN_MAX    = 8'h1F;
    localparam logic [7:0] LEN_BIAS   = 8'd15;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    // one payload byte headed for the word store
    typedef struct packed {
        logic             en;
        logic             commit;
        logic [IDX_W-1:0] word;
        logic [2:0]       lane;
        logic [7:0]       data;
    } t_pay_wr;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* hdl/csfp_store.sv */
module csfp_store #(
    parameter int PAYLOAD_WORDS = csfp_pkg::PAYLOAD_WORDS_DEF
) (
    input  logic                         i_clk,
    input  csfp_pkg::t_pay_wr            i_wr,
    input  logic                         i_rd_en,
    input  logic [csfp_pkg::IDX_W-1:0]   i_rd_word,
    output logic [csfp_pkg::WORD_W-1:0]  o_rd_data
);
    import csfp_pkg::*;

    localparam int AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

    logic [WORD_W-1:0] r_mem [PAYLOAD_WORDS];
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [WORD_W-1:0] r_rd_data;

    // first byte of a word starts from zero, so a short last word is zero-filled
    always_comb begin
        n_word = (i_wr.lane == 3'd0) ? '0 : r_word;
        n_word = n_word | ({{(WORD_W-8){1'b0}}, i_wr.data} << {i_wr.lane, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_word <= n_word;
            if (i_wr.commit) begin
                r_mem[i_wr.word[AW-1:0]] <= n_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_word[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/can_over_serial_frame_parser_core.sv */
// Byte-stream deframer for CAN frames carried over a serial link. Each accepted
// byte is parsed in turn: header, little-endian id, payload and check
// (byte sum for type 0x44 frames, CRC-32 for type 0x66 frames). Payload bytes
// are packed into 8-byte words held in an internal word memory. A bad header
// byte or a check mismatch gives one error result. A good frame gives one
// result per payload word; each word passes through a memory read, then a load
// of the output register, and the input is held while the words of a frame
// drain and while the output stalls. Results wait in an output register; a byte
// is taken only while that register is empty or being drained.
module can_over_serial_frame_parser_core #(
    parameter int PAYLOAD_WORDS = csfp_pkg::PAYLOAD_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [csfp_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [csfp_pkg::KIND_W-1:0]   o_kind,
    output logic [csfp_pkg::ID_W-1:0]     o_frame_id,
    output logic [csfp_pkg::LEN_W-1:0]    o_payload_bytes,
    output logic [csfp_pkg::IDX_W-1:0]    o_word_index,
    output logic [csfp_pkg::WORD_W-1:0]   o_data_word,
    output logic                          o_last
);
    import csfp_pkg::*;

    localparam logic [LEN_W-1:0] MAX_BYTES = LEN_W'(8 * PAYLOAD_WORDS);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic              r_flag, n_flag;
    logic [7:0]        r_sum, n_sum;
    logic [31:0]       r_crc, n_crc;
    logic [LEN_W-1:0]  r_size, n_size;
    logic [ID_W-1:0]   r_id, n_id;
    logic [31:0]       r_rc, n_rc;
    logic [IDX_W-1:0]  r_emit_w, n_emit_w;
    logic [IDX_W:0]    r_nwords, n_nwords;

    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [WORD_W-1:0] r_out_data, n_out_data;
    logic              r_out_last, n_out_last;

    logic              out_free;
    logic              acc;
    logic [7:0]        b;
    logic              upd_flag;
    logic              upd;
    logic [7:0]        len_tmp;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  k_pay;
    logic [LEN_W-1:0]  k_chk;
    logic              send_last;
    t_pay_wr           wr;
    logic [WORD_W-1:0] rd_data;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == ST_RUN) && out_free);
    assign acc      = i_valid && !o_stall;
    assign b        = i_rx_byte;
    assign len_tmp  = b - LEN_BIAS;
    assign len      = {len_tmp[4:0], 2'b00};
    assign k_pay    = r_pos - 7'd8;
    assign k_chk    = r_pos - r_size - 7'd8;
    assign send_last = ({1'b0, r_emit_w} + 4'd1) == r_nwords;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_flag   = r_flag;
        n_sum    = r_sum;
        n_crc    = r_crc;
        n_size   = r_size;
        n_id     = r_id;
        n_rc     = r_rc;
        n_emit_w = r_emit_w;
        n_nwords = r_nwords;

        n_out_valid = r_out_valid && i_stall;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_len   = r_out_len;
        n_out_idx   = r_out_idx;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        wr       = '0;
        wr.data  = b;
        wr.lane  = k_pay[2:0];
        wr.word  = k_pay[5:3];
        upd      = 1'b0;
        upd_flag = (r_pos == 7'd0) ? (b == HDR_CRC) : r_flag;

        unique case (r_state)
            ST_RUN: begin
                if (acc) begin
                    if (r_pos < 7'd4) begin
                        logic bad;
                        bad = 1'b0;
                        unique case (r_pos[1:0])
                            2'd0: bad = (b != HDR_SUM) && (b != HDR_CRC);
                            2'd1: bad = (b != HDR_SYNC1);
                            2'd2: bad = (b != HDR_SYNC2);
                            default: begin
                                if (!r_flag) begin
                                    bad = (b != LEN_MIN);
                                end else begin
                                    bad = (b < LEN_MIN) || (b > LEN_MAX);
                                end
                                bad = bad || (len > MAX_BYTES);
                            end
                        endcase
                        if (bad) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_HDR;
                            n_out_id    = '0;
                            n_out_len   = '0;
                            n_out_idx   = '0;
                            n_out_data  = '0;
                            n_out_last  = 1'b1;
                            n_pos  = '0;
                            n_flag = 1'b0;
                            n_sum  = '0;
                            n_crc  = CRC_INIT;
                            n_size = 7'd8;
                            n_rc   = '0;
                        end else begin
                            if (r_pos == 7'd0) begin
                                n_flag = upd_flag;
                            end
                            if (r_pos == 7'd3) begin
                                n_size = len;
                            end
                            upd   = 1'b1;
                            n_pos = r_pos + 7'd1;
                        end
                    end else if (r_pos < 7'd8) begin
                        case (r_pos[1:0])
                            2'd0:    n_id = {24'd0, b};
                            2'd1:    n_id = r_id | {16'd0, b, 8'd0};
                            2'd2:    n_id = r_id | {8'd0, b, 16'd0};
                            default: n_id = r_id | {b, 24'd0};
                        endcase
                        upd   = 1'b1;
                        n_pos = r_pos + 7'd1;
                    end else if (r_pos < r_size + 7'd8) begin
                        wr.en     = 1'b1;
                        wr.commit = (k_pay[2:0] == 3'd7) || (r_pos == r_size + 7'd7);
                        upd       = 1'b1;
                        n_pos     = r_pos + 7'd1;
                    end else begin
                        logic done;
                        logic good;
                        done = 1'b1;
                        good = 1'b0;
                        if (r_flag) begin
                            case (k_chk[1:0])
                                2'd0:    n_rc = r_rc | {24'd0, b};
                                2'd1:    n_rc = r_rc | {16'd0, b, 8'd0};
                                2'd2:    n_rc = r_rc | {8'd0, b, 16'd0};
                                default: n_rc = r_rc | {b, 24'd0};
                            endcase
                            if (k_chk[1:0] != 2'd3) begin
                                done  = 1'b0;
                                n_pos = r_pos + 7'd1;
                            end else begin
                                good = (~r_crc) == {b, r_rc[23:0]};
                            end
                        end else begin
                            good = (r_sum == b);
                        end
                        if (done) begin
                            n_pos  = '0;
                            n_flag = 1'b0;
                            n_sum  = '0;
                            n_crc  = CRC_INIT;
                            n_rc   = '0;
                            if (good) begin
                                // keep the length for the word burst
                                n_state  = ST_READ;
                                n_emit_w = '0;
                                n_nwords = r_size[6:3] + {3'd0, (r_size[2:0] != 3'd0)};
                            end else begin
                                n_size      = 7'd8;
                                n_out_valid = 1'b1;
                                n_out_kind  = KIND_CHECK;
                                n_out_id    = '0;
                                n_out_len   = '0;
                                n_out_idx   = '0;
                                n_out_data  = '0;
                                n_out_last  = 1'b1;
                            end
                        end
                    end
                    if (upd) begin
                        if (upd_flag) begin
                            n_crc = crc_byte(r_crc, b);
                        end else begin
                            n_sum = r_sum + b;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_OK;
                    n_out_id    = r_id;
                    n_out_len   = r_size;
                    n_out_idx   = r_emit_w;
                    n_out_data  = rd_data;
                    n_out_last  = send_last;
                    if (send_last) begin
                        n_size  = 7'd8;
                        n_state = ST_RUN;
                    end else begin
                        n_emit_w = r_emit_w + 3'd1;
                        n_state  = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    csfp_store #(
        .PAYLOAD_WORDS(PAYLOAD_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_word (r_emit_w),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_pos       <= '0;
            r_flag      <= 1'b0;
            r_sum       <= '0;
            r_crc       <= CRC_INIT;
            r_size      <= 7'd8;
            r_id        <= '0;
            r_rc        <= '0;
            r_emit_w    <= '0;
            r_nwords    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_flag      <= n_flag;
            r_sum       <= n_sum;
            r_crc       <= n_crc;
            r_size      <= n_size;
            r_id        <= n_id;
            r_rc        <= n_rc;
            r_emit_w    <= n_emit_w;
            r_nwords    <= n_nwords;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_len  <= n_out_len;
        r_out_idx  <= n_out_idx;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_frame_id      = r_out_id;
    assign o_payload_bytes = r_out_len;
    assign o_word_index    = r_out_idx;
    assign o_data_word     = r_out_data;
    assign o_last          = r_out_last;

endmodule

/* hdl/csfp_chk.sv */
module csfp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [csfp_pkg::KIND_W-1:0]   o_kind,
    input logic [csfp_pkg::ID_W-1:0]     o_frame_id,
    input logic [csfp_pkg::LEN_W-1:0]    o_payload_bytes,
    input logic [csfp_pkg::IDX_W-1:0]    o_word_index,
    input logic [csfp_pkg::WORD_W-1:0]   o_data_word,
    input logic                          o_last
);
    import csfp_pkg::*;

    logic [IDX_W:0] nwords;
    assign nwords = 4'((o_payload_bytes + 7'd7) >> 3);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_word) && $stable(o_kind)
            && $stable(o_word_index) && $stable(o_last))
        else $error("stalled result changed");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_OK) |-> o_last && (o_frame_id == '0)
            && (o_payload_bytes == '0) && (o_data_word == '0))
        else $error("error result not a single zeroed transfer");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_OK) |-> (o_payload_bytes[1:0] == 2'b00)
            && (o_payload_bytes >= 7'd8) && (o_payload_bytes <= 7'd64))
        else $error("bad payload length on good frame");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_OK) |->
            (o_last == ({1'b0, o_word_index} == nwords - 4'd1))
            && ({1'b0, o_word_index} < nwords))
        else $error("last flag does not match final payload word");

    // a short final word has its upper half zero
    a_zero_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_OK) && o_last && (o_payload_bytes[2:0] != 3'd0)
            |-> (o_data_word[63:32] == 32'd0))
        else $error("short last word not zero-filled");

endmodule

bind can_over_serial_frame_parser_core csfp_chk u_csfp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_frame_id      (o_frame_id),
    .o_payload_bytes (o_payload_bytes),
    .o_word_index    (o_word_index),
    .o_data_word     (o_data_word),
    .o_last          (o_last)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import csfp_pkg::*;

    localparam int PW          = PAYLOAD_WORDS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  payload_bytes;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] data_word;
        logic              last;
    } t_deframed;

    typedef struct {
        logic [7:0] value;
        bit         hold;   // wait for every pending word before this byte
    } t_rx_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [KIND_W-1:0] o_kind;
    logic [ID_W-1:0]   o_frame_id;
    logic [LEN_W-1:0]  o_payload_bytes;
    logic [IDX_W-1:0]  o_word_index;
    logic [WORD_W-1:0] o_data_word;
    logic              o_last;

    t_rx_item  tx_bytes[$];
    t_deframed expected_results[$];
    int        mismatch_count = 0;
    int        sent_count = 0;
    int        cycle_count = 0;
    logic      calm;

    // deframer shadow state
    int          rx_pos;
    bit          crc_mode;
    logic [7:0]  sum_acc;
    logic [31:0] crc_acc;
    int          frame_len;
    logic [31:0] frame_id_acc = '0;
    logic [63:0] word_store [PW];
    logic [31:0] check_rx;

    can_over_serial_frame_parser_core #(
        .PAYLOAD_WORDS(PW)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_frame_id     (o_frame_id),
        .o_payload_bytes(o_payload_bytes),
        .o_word_index   (o_word_index),
        .o_data_word    (o_data_word),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // no idling on either side over a stretch of the run
    assign calm = (sent_count >= 120) && (sent_count < 220);

    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            c = {1'b0, c[31:1]} ^ ((c[0] ^ b[i]) ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    task automatic parser_restart();
        rx_pos    = 0;
        crc_mode  = 1'b0;
        sum_acc   = '0;
        crc_acc   = CRC_INIT;
        frame_len = 8;
        check_rx  = '0;
    endtask

    task automatic fold_check(input logic [7:0] b);
        if (crc_mode) begin
            crc_acc = crc32_step(crc_acc, b);
        end else begin
            sum_acc = sum_acc + b;
        end
    endtask

    task automatic frame_failed(input logic [KIND_W-1:0] kind);
        t_deframed r;
        r      = '0;
        r.kind = kind;
        r.last = 1'b1;
        expected_results.push_back(r);
        parser_restart();
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        bit        hdr_ok;
        int        k;
        int        nwords;
        t_deframed r;
        if (rx_pos < 4) begin
            case (rx_pos)
                0: hdr_ok = (b == HDR_SUM) || (b == HDR_CRC);
                1: hdr_ok = (b == HDR_SYNC1);
                2: hdr_ok = (b == HDR_SYNC2);
                default: hdr_ok = crc_mode ? (b >= LEN_MIN && b <= LEN_MAX) : (b == LEN_MIN);
            endcase
            // a length past the word store counts as a bad header byte
            if (rx_pos == 3 && hdr_ok && (int'(b) - int'(LEN_BIAS)) * 4 > 8 * PW) hdr_ok = 1'b0;
            if (!hdr_ok) begin
                frame_failed(KIND_HDR);
            end else begin
                if (rx_pos == 0) crc_mode = (b == HDR_CRC);
                if (rx_pos == 3) frame_len = (int'(b) - int'(LEN_BIAS)) * 4;
                fold_check(b);
                rx_pos++;
            end
        end else if (rx_pos < 8) begin
            frame_id_acc[8 * (rx_pos - 4) +: 8] = b;
            fold_check(b);
            rx_pos++;
        end else if (rx_pos < 8 + frame_len) begin
            k = rx_pos - 8;
            if (k % 8 == 0) word_store[k / 8] = '0;
            word_store[k / 8][8 * (k % 8) +: 8] = b;
            fold_check(b);
            rx_pos++;
        end else if (crc_mode && rx_pos < 8 + frame_len + 3) begin
            check_rx[8 * (rx_pos - 8 - frame_len) +: 8] = b;
            rx_pos++;
        end else begin
            if (crc_mode) check_rx[31:24] = b;
            if (crc_mode ? (~crc_acc != check_rx) : (sum_acc != b)) begin
                frame_failed(KIND_CHECK);
            end else begin
                nwords = (frame_len + 7) / 8;
                for (int w = 0; w < nwords; w++) begin
                    r.kind          = KIND_OK;
                    r.frame_id      = frame_id_acc;
                    r.payload_bytes = LEN_W'(frame_len);
                    r.word_index    = IDX_W'(w);
                    r.data_word     = word_store[w];
                    if (frame_len - 8 * w < 8) begin
                        r.data_word &= ~({WORD_W{1'b1}} << (8 * (frame_len - 8 * w)));
                    end
                    r.last = (w == nwords - 1);
                    expected_results.push_back(r);
                end
                parser_restart();
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] value, input bit hold);
        t_rx_item it;
        it.value = value;
        it.hold  = hold;
        tx_bytes.push_back(it);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_frame(input logic [7:0] lead, input logic [7:0] len_code,
                             input logic [31:0] id, input bit corrupt, input bit hold);
        logic [7:0]  seq[$];
        logic [7:0]  sum;
        logic [31:0] crc;
        int          n;
        seq.push_back(lead);
        seq.push_back(HDR_SYNC1);
        seq.push_back(HDR_SYNC2);
        seq.push_back(len_code);
        for (int i = 0; i < 4; i++) seq.push_back(id[8 * i +: 8]);
        n = (int'(len_code) - int'(LEN_BIAS)) * 4;
        repeat (n) seq.push_back(pick_byte());
        sum = '0;
        crc = CRC_INIT;
        foreach (seq[i]) begin
            sum = sum + seq[i];
            crc = crc32_step(crc, seq[i]);
        end
        crc = ~crc;
        if (lead == HDR_CRC) begin
            if (corrupt) crc ^= 32'd1 << $urandom_range(0, 31);
            for (int i = 0; i < 4; i++) seq.push_back(crc[8 * i +: 8]);
        end else begin
            if (corrupt) sum ^= 8'($urandom_range(1, 255));
            seq.push_back(sum);
        end
        foreach (seq[i]) push_byte(seq[i], hold && i == 0);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("ERROR t=%0t %0s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // sender: launch a byte when the slot frees up; predict on launch, since the
    // byte after the one that closes a frame is held while its words drain
    always @(posedge i_clk) begin : drive
        t_rx_item head;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) sent_count <= sent_count + 1;
            if (!i_valid || !o_stall) begin
                if (tx_bytes.size() == 0
                        || (tx_bytes[0].hold && expected_results.size() != 0)
                        || (!calm && $urandom_range(0, 99) < 25)) begin
                    i_valid <= 1'b0;
                end else begin
                    head = tx_bytes.pop_front();
                    parse_rx_byte(head.value);
                    i_rx_byte <= head.value;
                    i_valid   <= 1'b1;
                end
            end
        end
    end

    // receiver: check each transfer against the oldest expected word
    always @(posedge i_clk) begin : watch
        t_deframed want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with nothing expected, data_word", o_data_word, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_kind != want.kind) flag_mismatch("kind", o_kind, want.kind);
                    if (o_frame_id != want.frame_id)
                        flag_mismatch("frame_id", o_frame_id, want.frame_id);
                    if (o_payload_bytes != want.payload_bytes)
                        flag_mismatch("payload_bytes", o_payload_bytes, want.payload_bytes);
                    if (o_word_index != want.word_index)
                        flag_mismatch("word_index", o_word_index, want.word_index);
                    if (o_data_word != want.data_word)
                        flag_mismatch("data_word", o_data_word, want.data_word);
                    if (o_last != want.last) flag_mismatch("last", o_last, want.last);
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("can_over_serial_frame_parser_core: mismatch");
            $finish;
        end
    end

    initial begin
        int         pick;
        int         cut;
        logic [7:0] lead;
        logic [7:0] len_code;
        logic [7:0] bad;

        parser_restart();

        // directed: good sum frame at the id extreme, bad bytes at header slots 0, 2 and 3
        add_frame(HDR_SUM, LEN_MIN, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(HDR_SUM, 1'b0);
        push_byte(HDR_SYNC1, 1'b0);
        push_byte(HDR_SYNC2, 1'b0);
        push_byte(LEN_MIN + 8'd1, 1'b0);
        push_byte(HDR_CRC, 1'b0);
        push_byte(HDR_SYNC1, 1'b0);
        push_byte(8'h20, 1'b0);

        // longest payload, then a short one with a broken CRC; hold for drains
        add_frame(HDR_CRC, LEN_MAX, pick_id(), 1'b0, 1'b1);
        add_frame(HDR_CRC, LEN_MIN, pick_id(), 1'b1, 1'b1);

        while (tx_bytes.size() < 300) begin
            pick = $urandom_range(0, 99);
            lead = $urandom_range(0, 1) ? HDR_CRC : HDR_SUM;
            if (pick < 70) begin
                if (lead == HDR_SUM) begin
                    len_code = LEN_MIN;
                end else if ($urandom_range(0, 3) == 0) begin
                    len_code = 8'($urandom_range(LEN_MIN, LEN_MAX));
                end else begin
                    len_code = 8'($urandom_range(LEN_MIN, LEN_MIN + 2));
                end
                add_frame(lead, len_code, pick_id(), $urandom_range(0, 99) < 15,
                          $urandom_range(0, 9) == 0);
            end else if (pick < 85) begin
                // header cut short by a wrong byte
                cut = $urandom_range(1, 3);
                push_byte(lead, 1'b0);
                if (cut > 1) push_byte(HDR_SYNC1, 1'b0);
                if (cut > 2) push_byte(HDR_SYNC2, 1'b0);
                case (cut)
                    1: begin
                        do bad = 8'($urandom); while (bad == HDR_SYNC1);
                    end
                    2: begin
                        do bad = 8'($urandom); while (bad == HDR_SYNC2);
                    end
                    default: begin
                        if (lead == HDR_SUM && $urandom_range(0, 1) == 1) begin
                            bad = 8'($urandom_range(LEN_MIN + 1, LEN_MAX));
                        end else begin
                            do bad = 8'($urandom);
                            while (lead == HDR_CRC ? (bad >= LEN_MIN && bad <= LEN_MAX)
                                                   : (bad == LEN_MIN));
                        end
                    end
                endcase
                push_byte(bad, 1'b0);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    do bad = 8'($urandom); while (bad == HDR_SUM || bad == HDR_CRC);
                    push_byte(bad, 1'b0);
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            flag_mismatch("results never produced, count", expected_results.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("can_over_serial_frame_parser_core: match");
        end else begin
            $display("can_over_serial_frame_parser_core: mismatch");
        end
        $finish;
    end

endmodule
